/* hdl/dcpe_pkg.sv */
// Shared types and constants of the descriptor copy and pad engine.
`timescale 1ns / 1ps
package dcpe_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_XFER  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_GROUP = 2'd3;

	// Result status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DST_OOB = 2'd1;
	localparam logic [1:0] STATUS_SRC_OOB = 2'd2;

	// Configuration port.
	localparam int         PADDR_W           = 3;
	localparam int         PDATA_W           = 32;
	localparam logic       REG_SOURCE_LENGTH = 1'b0;

	// Field widths.
	localparam int ADDR_W = 12;
	localparam int LEN_W  = 13;
	localparam int WORD_W = 32;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] src_addr;
		logic [ADDR_W-1:0] dst_addr;
		logic [LEN_W-1:0]  xfer_len;
		logic              pad;
		logic [WORD_W-1:0] word_value;
		logic [LEN_W-1:0]  group_length;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic [1:0]        status;
	} out_t;

	// Classified command as it waits in the queue.
	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [LEN_W-1:0]  size;
		logic              pad;
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  glen;     // already saturated to the destination depth
		logic              load_ok;  // load index lies inside the source memory
	} cmd_t;

endpackage

/* hdl/dcpe_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module dcpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* hdl/dcpe_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module dcpe_front #(
	parameter int SOURCE_DEPTH = 4096,
	parameter int DEST_DEPTH   = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dcpe_pkg::in_t item,
	output logic          busy,
	output dcpe_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_pop
);

	// A group length never needs to exceed what a 13-bit field can hold.
	localparam int GLEN_CAP = (DEST_DEPTH > 8191) ? 8191 : DEST_DEPTH;

	dcpe_pkg::cmd_t                  entry_q [dcpe_pkg::QUEUE_DEPTH];
	dcpe_pkg::cmd_t                  new_cmd;
	logic [dcpe_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [dcpe_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [dcpe_pkg::QPTR_W:0]       count_q;
	logic                            push;

	always_comb begin
		push              = start && !busy;
		new_cmd.kind      = item.kind;
		new_cmd.src       = item.src_addr;
		new_cmd.dst       = item.dst_addr;
		new_cmd.size      = item.xfer_len;
		new_cmd.pad       = item.pad;
		new_cmd.word      = item.word_value;
		new_cmd.glen      = (32'(item.group_length) > GLEN_CAP) ?
			dcpe_pkg::LEN_W'(GLEN_CAP) : item.group_length;
		new_cmd.load_ok   = 32'(item.src_addr) < SOURCE_DEPTH;
	end

	assign busy      = count_q == (dcpe_pkg::QPTR_W + 1)'(dcpe_pkg::QUEUE_DEPTH);
	assign cmd_valid = count_q != '0;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	// The queue never pops an empty slot.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid)
		else $error("queue popped while empty");

	// A pushed item leaves the queue non-empty in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) push |=> count_q != '0)
		else $error("queue lost a pushed item");

endmodule

/* hdl/dcpe_back.sv */
// Back end: executes queued commands against the source and destination memories.
`timescale 1ns / 1ps
module dcpe_back #(
	parameter int SOURCE_DEPTH = 4096,
	parameter int DEST_DEPTH   = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dcpe_pkg::cmd_t               cmd,
	input  logic                         cmd_valid,
	output logic                         cmd_pop,
	input  logic [dcpe_pkg::LEN_W-1:0]   src_len,
	output logic                         done,
	output dcpe_pkg::out_t               result
);

	localparam int SAW   = $clog2(SOURCE_DEPTH);
	localparam int DAW   = $clog2(DEST_DEPTH);
	localparam int MAXAW = (SAW > DAW) ? SAW : DAW;
	localparam int PW    = (MAXAW > 14) ? MAXAW : 14;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_XFER  = 3'd1;
	localparam logic [2:0] ST_FLUSH = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;

	logic [2:0]                   state_q;
	logic [PW-1:0]                src_ptr_q;
	logic [PW-1:0]                dst_ptr_q;
	logic [dcpe_pkg::LEN_W-1:0]   remain_q;
	logic [dcpe_pkg::LEN_W-1:0]   glen_q;
	logic                         pad_q;
	logic [1:0]                   status_q;
	logic                         copy_s1;
	logic [DAW-1:0]               copy_addr_s1;
	logic                         done_q;
	dcpe_pkg::out_t               result_q;

	logic                         dst_oob;
	logic                         src_oob;
	logic [1:0]                   elem_status;
	logic                         copy_issue;
	logic                         read_hit;
	logic                         finish;

	logic                         src_we;
	logic [SAW-1:0]               src_waddr;
	logic [dcpe_pkg::WORD_W-1:0]  src_wdata;
	logic [SAW-1:0]               src_raddr;
	logic [dcpe_pkg::WORD_W-1:0]  src_rdata;
	logic                         dst_we;
	logic [DAW-1:0]               dst_waddr;
	logic [dcpe_pkg::WORD_W-1:0]  dst_wdata;
	logic [DAW-1:0]               dst_raddr;
	logic [dcpe_pkg::WORD_W-1:0]  dst_rdata;

	dcpe_ram #(.WIDTH(dcpe_pkg::WORD_W), .DEPTH(SOURCE_DEPTH)) u_src_ram (
		.clk     (clk),
		.wr_en   (src_we),
		.wr_addr (src_waddr),
		.wr_data (src_wdata),
		.rd_addr (src_raddr),
		.rd_data (src_rdata)
	);

	dcpe_ram #(.WIDTH(dcpe_pkg::WORD_W), .DEPTH(DEST_DEPTH)) u_dst_ram (
		.clk     (clk),
		.wr_en   (dst_we),
		.wr_addr (dst_waddr),
		.wr_data (dst_wdata),
		.rd_addr (dst_raddr),
		.rd_data (dst_rdata)
	);

	always_comb begin
		cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
		read_hit = {1'b0, cmd.dst} < glen_q;

		// An item with nothing to move finishes in its pop cycle; the others
		// finish in the last cycle of their working state.
		finish = (cmd_pop && ((cmd.kind == dcpe_pkg::KIND_LOAD) ||
				((cmd.kind == dcpe_pkg::KIND_XFER) && (cmd.size == '0)) ||
				((cmd.kind == dcpe_pkg::KIND_READ) && !read_hit) ||
				((cmd.kind == dcpe_pkg::KIND_GROUP) && (cmd.glen == '0)))) ||
			(state_q == ST_FLUSH) || (state_q == ST_READ) ||
			((state_q == ST_CLEAR) && (remain_q == dcpe_pkg::LEN_W'(1)));

		// Range checks of the current transfer element.
		dst_oob = dst_ptr_q >= PW'(glen_q);
		src_oob = (src_ptr_q >= PW'(src_len)) || (32'(src_ptr_q) >= SOURCE_DEPTH);
		if (dst_oob) begin
			elem_status = dcpe_pkg::STATUS_DST_OOB;
		end else if (!pad_q && src_oob) begin
			elem_status = dcpe_pkg::STATUS_SRC_OOB;
		end else begin
			elem_status = dcpe_pkg::STATUS_OK;
		end
		copy_issue = (state_q == ST_XFER) && !dst_oob && !pad_q && !src_oob;

		src_we    = cmd_pop && (cmd.kind == dcpe_pkg::KIND_LOAD) && cmd.load_ok;
		src_waddr = SAW'(cmd.src);
		src_wdata = cmd.word;
		src_raddr = src_ptr_q[SAW-1:0];
		dst_raddr = DAW'(cmd.dst);

		// Copies land in the cycle after the source read; pad and clear writes go
		// straight in. The two never meet within one command.
		if (copy_s1) begin
			dst_we    = 1'b1;
			dst_waddr = copy_addr_s1;
			dst_wdata = src_rdata;
		end else begin
			dst_we    = ((state_q == ST_XFER) && !dst_oob && pad_q) ||
				(state_q == ST_CLEAR);
			dst_waddr = dst_ptr_q[DAW-1:0];
			dst_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			copy_s1 <= 1'b0;
			glen_q  <= '0;
		end else begin
			done_q  <= finish;
			copy_s1 <= copy_issue;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							dcpe_pkg::KIND_LOAD: begin
								state_q <= ST_IDLE;
							end
							dcpe_pkg::KIND_XFER: begin
								if (cmd.size != '0) begin
									state_q <= ST_XFER;
								end
							end
							dcpe_pkg::KIND_READ: begin
								if (read_hit) begin
									state_q <= ST_READ;
								end
							end
							dcpe_pkg::KIND_GROUP: begin
								glen_q <= cmd.glen;
								if (cmd.glen != '0) begin
									state_q <= ST_CLEAR;
								end
							end
						endcase
					end
				end
				ST_XFER: begin
					if (remain_q == dcpe_pkg::LEN_W'(1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					if (remain_q == dcpe_pkg::LEN_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= dst_ptr_q[DAW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				src_ptr_q <= PW'(cmd.src);
				pad_q     <= cmd.pad;
				status_q  <= dcpe_pkg::STATUS_OK;
				result_q.read_value <= '0;
				if (cmd.kind == dcpe_pkg::KIND_GROUP) begin
					dst_ptr_q <= '0;
					remain_q  <= cmd.glen;
				end else begin
					dst_ptr_q <= PW'(cmd.dst);
					remain_q  <= cmd.size;
				end
				if ((cmd.kind == dcpe_pkg::KIND_READ) && !read_hit) begin
					result_q.status <= dcpe_pkg::STATUS_DST_OOB;
				end else begin
					result_q.status <= dcpe_pkg::STATUS_OK;
				end
			end
			ST_XFER: begin
				src_ptr_q <= src_ptr_q + PW'(1);
				dst_ptr_q <= dst_ptr_q + PW'(1);
				remain_q  <= remain_q - dcpe_pkg::LEN_W'(1);
				if (status_q == dcpe_pkg::STATUS_OK) begin
					status_q <= elem_status;
				end
			end
			ST_FLUSH: begin
				result_q.read_value <= '0;
				result_q.status     <= status_q;
			end
			ST_READ: begin
				result_q.read_value <= dst_rdata;
				result_q.status     <= dcpe_pkg::STATUS_OK;
			end
			ST_CLEAR: begin
				dst_ptr_q <= dst_ptr_q + PW'(1);
				remain_q  <= remain_q - dcpe_pkg::LEN_W'(1);
			end
			default: begin
				remain_q <= remain_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	// A copy in flight always comes from a transfer cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		copy_s1 |-> $past(state_q) == ST_XFER)
		else $error("copy write without a transfer cycle");

	// The clearing pass stays inside the new group.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (dst_ptr_q < PW'(glen_q)))
		else $error("clear pass ran past the group length");

	// No copy may still be landing while a group is being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !copy_s1)
		else $error("copy write overlapped the clear pass");

	// A result flagged out of range never carries data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != dcpe_pkg::STATUS_OK)) |-> (result.read_value == '0))
		else $error("out-of-range result carries a value");

endmodule

/* hdl/descriptor_copy_pad_engine_top.sv */
// Top level of the descriptor copy and pad engine with its configuration port.
`timescale 1ns / 1ps
// The engine takes one item at a clock edge where start is high and busy is low,
// and answers every item with exactly one result, shown on result for one cycle
// with done high; the receiver cannot stall it, and results come out in item
// order. A front end queues up to two items, so busy rises only when both queue
// slots are full. The back end works on one item at a time: a load, a read
// outside the group and a zero-length transfer finish when taken from the
// queue; a read inside the group passes through a read state; a transfer
// moves one word per cycle through the source read and the destination write
// and ends in a flush state; a start-group item clears the first L words of
// the destination memory one a cycle, where L is the saturated group length.
// Words beyond the group length need no clearing since they can be neither
// read nor written while that group is current. The result appears in the
// cycle after the item finishes. source_length is written through the APB
// port at byte address 0 and must only change while the engine is idle.
module descriptor_copy_pad_engine_top #(
	parameter int SOURCE_DEPTH = 4096,
	parameter int DEST_DEPTH   = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  dcpe_pkg::in_t                    item,
	output logic                             busy,
	output logic                             done,
	output dcpe_pkg::out_t                   result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dcpe_pkg::PADDR_W-1:0]     paddr,
	input  logic [dcpe_pkg::PDATA_W-1:0]     pwdata,
	output logic [dcpe_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	logic [dcpe_pkg::LEN_W-1:0] src_len_q;
	logic                       reg_sel;
	dcpe_pkg::cmd_t             cmd;
	logic                       cmd_valid;
	logic                       cmd_pop;

	// Register index is the word address; only source_length exists.
	assign reg_sel = paddr[dcpe_pkg::PADDR_W-1] == dcpe_pkg::REG_SOURCE_LENGTH;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? dcpe_pkg::PDATA_W'(src_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_len_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			src_len_q <= pwdata[dcpe_pkg::LEN_W-1:0];
		end
	end

	// Front end: accepts and classifies items into a two-entry queue.
	dcpe_front #(.SOURCE_DEPTH(SOURCE_DEPTH), .DEST_DEPTH(DEST_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	// Back end: owns both memories and produces one result per item.
	dcpe_back #(.SOURCE_DEPTH(SOURCE_DEPTH), .DEST_DEPTH(DEST_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.src_len   (src_len_q),
		.done      (done),
		.result    (result)
	);

endmodule
